FILE: src/perceptron_branch_predictor_assert.svh
// Assertion macros for the perceptron branch predictor.
// Used by the modules that carry concurrent checks; expects i_clk and i_rst_n.
`ifndef PERCEPTRON_BRANCH_PREDICTOR_ASSERT_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define PBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define PBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pbp_pkg.sv
// Shared types and constants of the perceptron branch predictor.
// No dependencies; used by every module of the block.
`default_nettype none

package pbp_pkg;

    // Table geometry
    localparam int NUM_ENTRIES = 256;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int HIST_LEN    = 16;
    localparam int ROW_LEN     = HIST_LEN + 1;
    localparam int PC_IDX_LSB  = 2;

    // Perceptron output range
    localparam int SUM_W   = 13;
    localparam int SUM_MAX = 4095;
    localparam int SUM_MIN = -4096;

    // Training threshold register
    localparam int THR_W     = 10;
    localparam int THR_RESET = 45;

    // Weight value after reset, clamped to the weight range where used
    localparam int INIT_WEIGHT = 0;

    typedef enum logic [1:0] {
        MODE_LOOKUP  = 2'd0,
        MODE_HIST    = 2'd1,
        MODE_TRAIN   = 2'd2,
        MODE_RESTORE = 2'd3
    } t_mode;

    // Weight memory port request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_mem_req;

endpackage

`default_nettype wire

FILE: src/pbp_weight_ram.sv
// Weight row memory: one write port, one registered read port with write bypass.
// Per-row valid bits make unwritten rows read as the initial weight. Uses pbp_pkg.
`default_nettype none

module pbp_weight_ram #(
    parameter int WEIGHT_BITS = 8
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  pbp_pkg::t_mem_req                        i_rd,
    input  pbp_pkg::t_mem_req                        i_wr,
    input  wire [pbp_pkg::ROW_LEN*WEIGHT_BITS-1:0]   i_wdata,
    output logic [pbp_pkg::ROW_LEN*WEIGHT_BITS-1:0]  o_rdata
);

    localparam int ROW_W = pbp_pkg::ROW_LEN * WEIGHT_BITS;
    localparam int W_MAX = (1 << (WEIGHT_BITS - 1)) - 1;
    localparam int W_MIN = -(1 << (WEIGHT_BITS - 1));
    localparam int INIT_CL = (pbp_pkg::INIT_WEIGHT > W_MAX) ? W_MAX :
                             (pbp_pkg::INIT_WEIGHT < W_MIN) ? W_MIN :
                             pbp_pkg::INIT_WEIGHT;
    localparam logic [WEIGHT_BITS-1:0] INIT_W = WEIGHT_BITS'(INIT_CL);
    localparam logic [ROW_W-1:0] INIT_ROW = {pbp_pkg::ROW_LEN{INIT_W}};

    logic [ROW_W-1:0]                r_mem [pbp_pkg::NUM_ENTRIES];
    logic [pbp_pkg::NUM_ENTRIES-1:0] r_vld;
    logic [ROW_W-1:0]                r_rdata;

    // Row valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Storage and registered read; a same-edge write to the read row is bypassed
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wdata;
        end
        if (i_rd.en) begin
            if (i_wr.en && (i_wr.addr == i_rd.addr)) begin
                r_rdata <= i_wdata;
            end else if (r_vld[i_rd.addr]) begin
                r_rdata <= r_mem[i_rd.addr];
            end else begin
                r_rdata <= INIT_ROW;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/pbp_perceptron.sv
// Perceptron arithmetic: history-signed dot product with saturation, and the
// +/-1 saturating training update of one weight row. Uses pbp_pkg.
`default_nettype none

module pbp_perceptron #(
    parameter int WEIGHT_BITS = 8
) (
    input  wire [pbp_pkg::ROW_LEN*WEIGHT_BITS-1:0]   i_row,
    input  wire [pbp_pkg::HIST_LEN-1:0]              i_hist,
    input  wire [pbp_pkg::HIST_LEN-1:0]              i_train_hist,
    input  wire                                      i_taken,
    output logic signed [pbp_pkg::SUM_W-1:0]         o_sum,
    output logic [pbp_pkg::ROW_LEN*WEIGHT_BITS-1:0]  o_row_trained
);

    localparam int WB = WEIGHT_BITS;
    localparam int HL = pbp_pkg::HIST_LEN;
    // Seventeen terms need five extra bits; keep at least the output width
    localparam int SW = (WB + 5 > pbp_pkg::SUM_W + 1) ? WB + 5 : pbp_pkg::SUM_W + 1;
    localparam logic signed [SW-1:0] SMAX = SW'(pbp_pkg::SUM_MAX);
    localparam logic signed [SW-1:0] SMIN = SW'(pbp_pkg::SUM_MIN);
    localparam logic [WB-1:0] W_MAX_U = {1'b0, {(WB - 1){1'b1}}};
    localparam logic [WB-1:0] W_MIN_U = {1'b1, {(WB - 1){1'b0}}};

    logic signed [SW-1:0] term [HL];
    logic signed [SW-1:0] lvl1 [HL/2];
    logic signed [SW-1:0] lvl2 [HL/4];
    logic signed [SW-1:0] lvl3 [HL/8];
    logic signed [SW-1:0] total;

    // One step toward the saturation bound
    function automatic logic [WB-1:0] sat_step(input logic [WB-1:0] w, input logic up);
        logic [WB-1:0] res;
        if (up) begin
            res = (w == W_MAX_U) ? w : w + WB'(1);
        end else begin
            res = (w == W_MIN_U) ? w : w - WB'(1);
        end
        return res;
    endfunction

    // History-signed terms
    always_comb begin
        for (int k = 0; k < HL; k++) begin
            term[k] = i_hist[k] ? SW'(signed'(i_row[(k + 1) * WB +: WB]))
                                : -SW'(signed'(i_row[(k + 1) * WB +: WB]));
        end
    end

    // Balanced adder tree over the sixteen terms, bias added last
    always_comb begin
        for (int j = 0; j < HL / 2; j++) begin
            lvl1[j] = term[2 * j] + term[2 * j + 1];
        end
        for (int j = 0; j < HL / 4; j++) begin
            lvl2[j] = lvl1[2 * j] + lvl1[2 * j + 1];
        end
        for (int j = 0; j < HL / 8; j++) begin
            lvl3[j] = lvl2[2 * j] + lvl2[2 * j + 1];
        end
        total = SW'(signed'(i_row[WB-1:0])) + lvl3[0] + lvl3[1];
    end

    // Clamp to the output range
    always_comb begin
        if (total > SMAX) begin
            o_sum = pbp_pkg::SUM_W'(pbp_pkg::SUM_MAX);
        end else if (total < SMIN) begin
            o_sum = pbp_pkg::SUM_W'(pbp_pkg::SUM_MIN);
        end else begin
            o_sum = total[pbp_pkg::SUM_W-1:0];
        end
    end

    // Training: bias follows the outcome, each weight agrees or disagrees with its bit
    always_comb begin
        o_row_trained[WB-1:0] = sat_step(i_row[WB-1:0], i_taken);
        for (int k = 0; k < HL; k++) begin
            o_row_trained[(k + 1) * WB +: WB] =
                sat_step(i_row[(k + 1) * WB +: WB], i_taken == i_train_hist[k]);
        end
    end

endmodule

`default_nettype wire

FILE: src/perceptron_branch_predictor.sv
// Perceptron branch predictor: one stream in, one result per transfer out, no
// stall of its own. An item is taken in every cycle unless m_axis_tready stalls
// a full stage 1; results pass stage 1 with the registered row read, then the
// output register, and the next item may enter while one waits. Lookups predict
// from the global history and the row at (pc >> 2) mod 256; history updates
// shift the outcome in; training adjusts the saved row by +/-1 with saturation;
// squash restores reload the history. The user must write the threshold
// register via i_cfg_we / i_cfg_wdata only while idle, not enforced by the block.
// Depends on pbp_pkg, pbp_weight_ram, pbp_perceptron and the assertion header.
`default_nettype none

`include "perceptron_branch_predictor_assert.svh"

module perceptron_branch_predictor #(
    parameter int WEIGHT_BITS = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // Threshold register write
    input  wire                         i_cfg_we,
    input  wire [pbp_pkg::THR_W-1:0]    i_cfg_wdata,
    // Request stream
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata from bit 0: pc[63:0], taken, uncond, squashed, saved_index[7:0],
    // saved_history[15:0], saved_sum[12:0], saved_prediction, 7 zero bits
    input  wire [111:0]                 s_axis_tdata,
    // tuser: mode[1:0]
    input  wire [1:0]                   s_axis_tuser,
    // Result stream
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // tdata from bit 0: prediction, sum_out[12:0], index_out[7:0],
    // history_out[15:0], 2 zero bits
    output logic [39:0]                 m_axis_tdata,
    // tuser: checkpoint_valid
    output logic                        m_axis_tuser
);

    localparam int ROW_W = pbp_pkg::ROW_LEN * WEIGHT_BITS;
    localparam int IW    = pbp_pkg::IDX_W;
    localparam int HL    = pbp_pkg::HIST_LEN;
    localparam int SW    = pbp_pkg::SUM_W;

    // Request fields
    pbp_pkg::t_mode     in_mode;
    logic [63:0]        in_pc;
    logic               in_taken;
    logic               in_uncond;
    logic               in_squashed;
    logic [IW-1:0]      in_sidx;
    logic [HL-1:0]      in_shist;
    logic signed [SW-1:0] in_ssum;
    logic               in_spred;
    logic               in_xfer;

    // Stage 1: registered request
    logic               r_s1_valid;
    pbp_pkg::t_mode     r_s1_mode;
    logic [IW-1:0]      r_s1_idx;
    logic               r_s1_taken;
    logic               r_s1_uncond;
    logic               r_s1_squashed;
    logic [IW-1:0]      r_s1_sidx;
    logic [HL-1:0]      r_s1_shist;
    logic signed [SW-1:0] r_s1_ssum;
    logic               r_s1_spred;
    logic               s1_adv;

    // Architectural state
    logic [pbp_pkg::THR_W-1:0] r_threshold;
    logic [HL-1:0]      r_hist;
    logic [HL-1:0]      n_hist;

    // Result register
    logic               r_out_valid;
    logic               r_out_pred;
    logic signed [SW-1:0] r_out_sum;
    logic [IW-1:0]      r_out_idx;
    logic [HL-1:0]      r_out_hist;
    logic               r_out_cv;

    // Stage 1 results
    logic               res_pred;
    logic signed [SW-1:0] res_sum;
    logic [IW-1:0]      res_idx;
    logic               res_cv;
    logic               train_do;
    logic [SW-1:0]      ssum_mag;

    // Memory and arithmetic
    pbp_pkg::t_mem_req  rd;
    pbp_pkg::t_mem_req  wr;
    logic [ROW_W-1:0]   row_rd;
    logic [ROW_W-1:0]   row_trained;
    logic signed [SW-1:0] pc_sum;

    // Unpack request
    assign in_mode     = pbp_pkg::t_mode'(s_axis_tuser);
    assign in_pc       = s_axis_tdata[63:0];
    assign in_taken    = s_axis_tdata[64];
    assign in_uncond   = s_axis_tdata[65];
    assign in_squashed = s_axis_tdata[66];
    assign in_sidx     = s_axis_tdata[74:67];
    assign in_shist    = s_axis_tdata[90:75];
    assign in_ssum     = signed'(s_axis_tdata[103:91]);
    assign in_spred    = s_axis_tdata[104];

    // Flow control
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Row read issued with the transfer
    assign rd.en   = in_xfer;
    assign rd.addr = (in_mode == pbp_pkg::MODE_TRAIN) ? in_sidx
                                                      : in_pc[pbp_pkg::PC_IDX_LSB +: IW];

    // Row write when a training item leaves stage 1
    assign wr.en   = s1_adv && train_do;
    assign wr.addr = r_s1_sidx;

    pbp_weight_ram #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd),
        .i_wr    (wr),
        .i_wdata (row_trained),
        .o_rdata (row_rd)
    );

    pbp_perceptron #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_perc (
        .i_row         (row_rd),
        .i_hist        (r_hist),
        .i_train_hist  (r_s1_shist),
        .i_taken       (r_s1_taken),
        .o_sum         (pc_sum),
        .o_row_trained (row_trained)
    );

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= pbp_pkg::THR_W'(pbp_pkg::THR_RESET);
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // Stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload; mode starts known so the decoder never sees an unknown code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_mode <= pbp_pkg::MODE_LOOKUP;
        end else if (in_xfer) begin
            r_s1_mode     <= in_mode;
            r_s1_idx      <= in_pc[pbp_pkg::PC_IDX_LSB +: IW];
            r_s1_taken    <= in_taken;
            r_s1_uncond   <= in_uncond;
            r_s1_squashed <= in_squashed;
            r_s1_sidx     <= in_sidx;
            r_s1_shist    <= in_shist;
            r_s1_ssum     <= in_ssum;
            r_s1_spred    <= in_spred;
        end
    end

    // Magnitude of the saved sum; -4096 maps to 4096 as unsigned
    assign ssum_mag = r_s1_ssum[SW-1] ? SW'(-r_s1_ssum) : SW'(r_s1_ssum);

    // Mode decode
    always_comb begin
        n_hist   = r_hist;
        res_pred = 1'b0;
        res_sum  = '0;
        res_idx  = '0;
        res_cv   = 1'b0;
        train_do = 1'b0;
        unique case (r_s1_mode)
            pbp_pkg::MODE_LOOKUP: begin
                res_pred = !pc_sum[SW-1];
                res_sum  = pc_sum;
                res_idx  = r_s1_idx;
                res_cv   = 1'b1;
            end
            pbp_pkg::MODE_HIST: begin
                if (r_s1_uncond) begin
                    res_pred = 1'b1;
                    res_sum  = SW'(r_threshold) + SW'(1);
                    res_idx  = r_s1_idx;
                    res_cv   = 1'b1;
                end
                n_hist = {r_hist[HL-2:0], r_s1_taken};
            end
            pbp_pkg::MODE_TRAIN: begin
                if (r_s1_squashed) begin
                    n_hist = r_s1_shist;
                end else begin
                    train_do = (r_s1_spred != r_s1_taken) ||
                               (ssum_mag <= SW'(r_threshold));
                end
            end
            pbp_pkg::MODE_RESTORE: begin
                n_hist = r_s1_shist;
            end
        endcase
    end

    // Global history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (s1_adv) begin
            r_hist <= n_hist;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pred <= res_pred;
            r_out_sum  <= res_sum;
            r_out_idx  <= res_idx;
            r_out_hist <= r_hist;
            r_out_cv   <= res_cv;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_hist, r_out_idx, r_out_sum, r_out_pred};
    assign m_axis_tuser  = r_out_cv;

    // Checks
    `PBP_ASSERT_IMP(a_wr_only_train, wr.en, r_s1_valid && (r_s1_mode == pbp_pkg::MODE_TRAIN) && !r_s1_squashed, "weight write outside a training transfer")
    `PBP_ASSERT_NEXT(a_s1_fill, in_xfer, r_s1_valid, "accepted item missing from stage 1")
    `PBP_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1_mode), "stalled stage 1 item lost")
    `PBP_ASSERT_IMP(a_plain_zero, r_out_valid && !r_out_cv, (r_out_pred == 1'b0) && (r_out_sum == '0) && (r_out_idx == '0), "non-checkpoint result carries fields")

endmodule

`default_nettype wire
